FILE: rtl/core/hill_cipher_2x2_top_macros.svh
// assertion helpers shared by the core
`ifndef HILL_CIPHER_2X2_TOP_MACROS_SVH
`define HILL_CIPHER_2X2_TOP_MACROS_SVH

// check with reset masking
`define HC_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// check that also holds through reset
`define HC_ASSERT(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/hc_pkg.sv
`default_nettype none

package hc_pkg;

    localparam int LETTER_W = 5;
    localparam int PROD_W   = 2 * LETTER_W;
    localparam int SUM_W    = PROD_W + 1;

    localparam int QDEPTH = 4;
    localparam int QIDX_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // cycles for a key write to reach the derived matrix
    localparam int          SETTLE_W   = 3;
    localparam logic [2:0]  SETTLE_CYC = 3'd5;

    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    typedef logic [LETTER_W-1:0] t_letter;
    typedef logic [2:0]          t_reg_idx;

    localparam t_reg_idx REG_KEY_TL = 3'd0;
    localparam t_reg_idx REG_KEY_TR = 3'd1;
    localparam t_reg_idx REG_KEY_BL = 3'd2;
    localparam t_reg_idx REG_KEY_BR = 3'd3;
    localparam t_reg_idx REG_MODE   = 3'd4;

    localparam t_letter ALPHA     = 5'd26 - 5'd0 == 5'd26 ? 5'd26 : 5'd26;
    localparam t_letter NO_INV_MULT = 5'd25;

    typedef struct packed {
        t_letter p0;
        t_letter p1;
    } t_pair;

    typedef struct packed {
        t_letter m00;
        t_letter m01;
        t_letter m10;
        t_letter m11;
        logic    key_not_invertible;
    } t_matrix;

    typedef struct packed {
        logic settled;
    } t_key_stat;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // fold a 5-bit value into 0..25
    function automatic t_letter red26(input t_letter x);
        return (x >= ALPHA) ? t_letter'(x - ALPHA) : x;
    endfunction

    // additive inverse mod 26 of a reduced value
    function automatic t_letter neg26(input t_letter x);
        return (x == 5'd0) ? 5'd0 : t_letter'(ALPHA - x);
    endfunction

    // x mod 26 for x below 1280: reciprocal estimate, then one correction
    function automatic t_letter mod26(input logic [SUM_W-1:0] x);
        logic [17:0]      t;
        logic [SUM_W-1:0] r;
        t = {7'd0, x} * 18'd78;
        r = x - ({4'd0, t[17:11]} * 11'd26);
        if (r >= 11'd26) begin
            r = r - 11'd26;
        end
        return r[LETTER_W-1:0];
    endfunction

    // multiplicative inverse mod 26, zero where none exists
    function automatic t_letter inv26(input t_letter x);
        t_letter r;
        case (x)
            5'd1:    r = 5'd1;
            5'd3:    r = 5'd9;
            5'd5:    r = 5'd21;
            5'd7:    r = 5'd15;
            5'd9:    r = 5'd3;
            5'd11:   r = 5'd19;
            5'd15:   r = 5'd7;
            5'd17:   r = 5'd23;
            5'd19:   r = 5'd11;
            5'd21:   r = 5'd5;
            5'd23:   r = 5'd17;
            5'd25:   r = 5'd25;
            default: r = 5'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/hc_chan_if.sv
`default_nettype none

interface hc_in_if;
    logic             valid;
    logic             ready;
    hc_pkg::t_letter  first_letter;
    hc_pkg::t_letter  second_letter;

    modport source (output valid, output first_letter, output second_letter, input ready);
    modport sink   (input valid, input first_letter, input second_letter, output ready);
endinterface

interface hc_out_if;
    logic             valid;
    logic             ready;
    hc_pkg::t_letter  first_out;
    hc_pkg::t_letter  second_out;
    logic             key_not_invertible;

    modport source (output valid, output first_out, output second_out,
                    output key_not_invertible, input ready);
    modport sink   (input valid, input first_out, input second_out,
                    input key_not_invertible, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/hc_key.sv
`default_nettype none

module hc_key (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [hc_pkg::APB_AW-1:0]   paddr,
    input  wire logic [hc_pkg::APB_DW-1:0]   pwdata,
    output logic      [hc_pkg::APB_DW-1:0]   o_prdata,
    output hc_pkg::t_matrix                  o_matrix,
    output hc_pkg::t_key_stat                o_stat
);

    hc_pkg::t_letter  r_key_tl, r_key_tr, r_key_bl, r_key_br;
    logic             r_mode;
    logic [hc_pkg::SETTLE_W-1:0] r_settle;
    hc_pkg::t_reg_idx reg_idx;
    logic             wr_en;

    // derivation pipeline
    hc_pkg::t_letter             r1_a, r1_b, r1_c, r1_d;
    logic [hc_pkg::PROD_W-1:0]   r1_ad, r1_bc;
    logic                        r1_mode;
    hc_pkg::t_letter             r2_a, r2_b, r2_c, r2_d, r2_ad, r2_bc;
    logic                        r2_mode;
    hc_pkg::t_letter             r3_a, r3_b, r3_c, r3_d, r3_mult;
    logic                        r3_noinv, r3_mode;
    logic [hc_pkg::PROD_W-1:0]   r4_p00, r4_p01, r4_p10, r4_p11;
    hc_pkg::t_letter             r4_a, r4_b, r4_c, r4_d;
    logic                        r4_noinv, r4_mode;
    hc_pkg::t_matrix             r_matrix;

    logic [5:0]       det_sum;
    hc_pkg::t_letter  n_det, n_inv;

    function automatic hc_pkg::t_letter det_low(input logic [5:0] x);
        return x[hc_pkg::LETTER_W-1:0];
    endfunction

    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_tl <= '0;
            r_key_tr <= '0;
            r_key_bl <= '0;
            r_key_br <= '0;
            r_mode   <= 1'b0;
        end else if (wr_en) begin
            case (reg_idx)
                hc_pkg::REG_KEY_TL: r_key_tl <= pwdata[hc_pkg::LETTER_W-1:0];
                hc_pkg::REG_KEY_TR: r_key_tr <= pwdata[hc_pkg::LETTER_W-1:0];
                hc_pkg::REG_KEY_BL: r_key_bl <= pwdata[hc_pkg::LETTER_W-1:0];
                hc_pkg::REG_KEY_BR: r_key_br <= pwdata[hc_pkg::LETTER_W-1:0];
                hc_pkg::REG_MODE:   r_mode   <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            hc_pkg::REG_KEY_TL: o_prdata = {27'd0, r_key_tl};
            hc_pkg::REG_KEY_TR: o_prdata = {27'd0, r_key_tr};
            hc_pkg::REG_KEY_BL: o_prdata = {27'd0, r_key_bl};
            hc_pkg::REG_KEY_BR: o_prdata = {27'd0, r_key_br};
            hc_pkg::REG_MODE:   o_prdata = {31'd0, r_mode};
            default:            o_prdata = '0;
        endcase
    end

    // hold off items until the new key has run through the pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle <= hc_pkg::SETTLE_CYC;
        end else if (wr_en) begin
            r_settle <= hc_pkg::SETTLE_CYC;
        end else if (r_settle != '0) begin
            r_settle <= r_settle - 1'b1;
        end
    end

    assign det_sum = {1'b0, r2_ad} + 6'd26 - {1'b0, r2_bc};
    assign n_det   = (det_sum >= 6'd26) ? det_low(det_sum - 6'd26) : det_low(det_sum);
    assign n_inv   = hc_pkg::inv26(n_det);

    always_ff @(posedge i_clk) begin
        // stage 1: reduce keys, det products
        r1_a    <= hc_pkg::red26(r_key_tl);
        r1_b    <= hc_pkg::red26(r_key_tr);
        r1_c    <= hc_pkg::red26(r_key_bl);
        r1_d    <= hc_pkg::red26(r_key_br);
        r1_ad   <= hc_pkg::red26(r_key_tl) * hc_pkg::red26(r_key_br);
        r1_bc   <= hc_pkg::red26(r_key_tr) * hc_pkg::red26(r_key_bl);
        r1_mode <= r_mode;
        // stage 2: reduce products
        r2_a    <= r1_a;
        r2_b    <= r1_b;
        r2_c    <= r1_c;
        r2_d    <= r1_d;
        r2_ad   <= hc_pkg::mod26({1'b0, r1_ad});
        r2_bc   <= hc_pkg::mod26({1'b0, r1_bc});
        r2_mode <= r1_mode;
        // stage 3: determinant and its inverse
        r3_a     <= r2_a;
        r3_b     <= r2_b;
        r3_c     <= r2_c;
        r3_d     <= r2_d;
        r3_noinv <= (n_inv == 5'd0);
        r3_mult  <= (n_inv == 5'd0) ? hc_pkg::NO_INV_MULT : n_inv;
        r3_mode  <= r2_mode;
        // stage 4: adjugate times multiplier
        r4_p00   <= r3_d * r3_mult;
        r4_p01   <= hc_pkg::neg26(r3_b) * r3_mult;
        r4_p10   <= hc_pkg::neg26(r3_c) * r3_mult;
        r4_p11   <= r3_a * r3_mult;
        r4_a     <= r3_a;
        r4_b     <= r3_b;
        r4_c     <= r3_c;
        r4_d     <= r3_d;
        r4_noinv <= r3_noinv;
        r4_mode  <= r3_mode;
        // stage 5: pick key or inverse
        if (r4_mode) begin
            r_matrix.m00 <= hc_pkg::mod26({1'b0, r4_p00});
            r_matrix.m01 <= hc_pkg::mod26({1'b0, r4_p01});
            r_matrix.m10 <= hc_pkg::mod26({1'b0, r4_p10});
            r_matrix.m11 <= hc_pkg::mod26({1'b0, r4_p11});
        end else begin
            r_matrix.m00 <= r4_a;
            r_matrix.m01 <= r4_b;
            r_matrix.m10 <= r4_c;
            r_matrix.m11 <= r4_d;
        end
        r_matrix.key_not_invertible <= r4_mode && r4_noinv;
    end

    assign o_matrix       = r_matrix;
    assign o_stat.settled = (r_settle == '0);

endmodule

`default_nettype wire

FILE: rtl/core/hc_front.sv
`default_nettype none

module hc_front (
    hc_in_if.sink                       i_pair,
    input  hc_pkg::t_key_stat           i_key_stat,
    input  hc_pkg::t_q_stat             i_q_stat,
    output logic                        o_push,
    output hc_pkg::t_pair               o_push_data
);

    // take a pair once the key is stable and the queue has room
    assign i_pair.ready   = i_key_stat.settled && !i_q_stat.full;
    assign o_push         = i_pair.valid && i_pair.ready;
    assign o_push_data.p0 = hc_pkg::red26(i_pair.first_letter);
    assign o_push_data.p1 = hc_pkg::red26(i_pair.second_letter);

endmodule

`default_nettype wire

FILE: rtl/core/hc_fifo.sv
`default_nettype none

`include "hill_cipher_2x2_top_macros.svh"

module hc_fifo (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_push,
    input  hc_pkg::t_pair               i_push_data,
    input  wire logic                   i_pop,
    output hc_pkg::t_pair               o_pop_data,
    output hc_pkg::t_q_stat             o_stat
);

    hc_pkg::t_pair               r_mem [hc_pkg::QDEPTH];
    logic [hc_pkg::QIDX_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [hc_pkg::QCNT_W-1:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_pop_data   = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == hc_pkg::QCNT_W'(hc_pkg::QDEPTH));
    assign o_stat.empty = (r_count == '0);

    `HC_ASSERT_RST(a_count_bound, i_clk, i_rst_n, r_count <= hc_pkg::QCNT_W'(hc_pkg::QDEPTH), "queue count overflow")
    `HC_ASSERT_RST(a_no_push_full, i_clk, i_rst_n, i_push |-> !o_stat.full, "push into full queue")
    `HC_ASSERT_RST(a_no_pop_empty, i_clk, i_rst_n, i_pop |-> !o_stat.empty, "pop from empty queue")

endmodule

`default_nettype wire

FILE: rtl/core/hc_back.sv
`default_nettype none

module hc_back (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  hc_pkg::t_q_stat             i_q_stat,
    input  hc_pkg::t_pair               i_pop_data,
    input  hc_pkg::t_matrix             i_matrix,
    output logic                        o_pop,
    hc_out_if.source                    o_result
);

    logic                        r_s1_valid, r_out_valid;
    logic [hc_pkg::PROD_W-1:0]   r_p00, r_p01, r_p10, r_p11;
    hc_pkg::t_letter             r_first, r_second;
    logic                        r_flag;
    logic                        out_en, s1_en;

    assign out_en = !r_out_valid || o_result.ready;
    assign s1_en  = !r_s1_valid || out_en;
    assign o_pop  = !i_q_stat.empty && s1_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_en) begin
                r_s1_valid <= o_pop;
            end
            if (out_en) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // matrix-vector products, then sums folded mod 26
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_p00 <= i_matrix.m00 * i_pop_data.p0;
            r_p01 <= i_matrix.m01 * i_pop_data.p1;
            r_p10 <= i_matrix.m10 * i_pop_data.p0;
            r_p11 <= i_matrix.m11 * i_pop_data.p1;
        end
        if (out_en && r_s1_valid) begin
            r_first  <= hc_pkg::mod26({1'b0, r_p00} + {1'b0, r_p01});
            r_second <= hc_pkg::mod26({1'b0, r_p10} + {1'b0, r_p11});
            r_flag   <= i_matrix.key_not_invertible;
        end
    end

    assign o_result.valid              = r_out_valid;
    assign o_result.first_out          = r_first;
    assign o_result.second_out         = r_second;
    assign o_result.key_not_invertible = r_flag;

endmodule

`default_nettype wire

FILE: rtl/core/hill_cipher_2x2_top.sv
// 2x2 hill cipher over letter indices 0..25
// i_pair carries a letter pair on a valid/ready channel; o_result returns the
// encrypted or decrypted pair plus key_not_invertible, one beat per input beat
// in order. the apb port holds the four key letters and the decrypt bit at
// byte offsets 0,4,8,12,16; pready is tied high, reads return the register.
// in decrypt mode the inverse matrix is adjugate times det^-1 mod 26; when the
// determinant has no inverse 25 stands in and the flag is set.
// an accepted beat passes the queue, the product register and the output
// register. throughput: one pair per cycle while o_result.ready stays high and
// no key is settling. a key or mode write runs through a 5-stage matrix
// derivation pipeline, and i_pair.ready stays low until the new matrix is out;
// reset clears the key, mode and all valid state and is followed by the same wait.
// a stalled receiver holds the output beat; the 4-entry queue between front
// and back keeps taking beats until it fills, then i_pair.ready drops
`default_nettype none

`include "hill_cipher_2x2_top_macros.svh"

module hill_cipher_2x2_top (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    hc_in_if.sink                            i_pair,
    hc_out_if.source                         o_result,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [hc_pkg::APB_AW-1:0]   paddr,
    input  wire logic [hc_pkg::APB_DW-1:0]   pwdata,
    output logic      [hc_pkg::APB_DW-1:0]   prdata,
    output logic                             pready
);

    hc_pkg::t_matrix    matrix;
    hc_pkg::t_key_stat  key_stat;
    hc_pkg::t_q_stat    q_stat;
    hc_pkg::t_pair      push_data, pop_data;
    logic               push, pop;

    // writes always finish in the access cycle
    assign pready = 1'b1;

    // key registers and inverse derivation
    hc_key u_key (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .o_prdata (prdata),
        .o_matrix (matrix),
        .o_stat   (key_stat)
    );

    // intake: range fold and flow control
    hc_front u_front (
        .i_pair      (i_pair),
        .i_key_stat  (key_stat),
        .i_q_stat    (q_stat),
        .o_push      (push),
        .o_push_data (push_data)
    );

    // decoupling queue
    hc_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_pop_data  (pop_data),
        .o_stat      (q_stat)
    );

    // multiply and reduce, output register
    hc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_stat   (q_stat),
        .i_pop_data (pop_data),
        .i_matrix   (matrix),
        .o_pop      (pop),
        .o_result   (o_result)
    );

    `HC_ASSERT_RST(a_accept_settled, i_clk, i_rst_n, push |-> key_stat.settled, "pair taken with stale key")

endmodule

`default_nettype wire

FILE: bench/hc_result_checker.sv
`default_nettype none

module hc_result_checker
    import hc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    hc_in_if                       i_pair,
    hc_out_if                      i_result,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    input  wire logic              pready,
    output int                     o_fail_count,
    output int                     o_results_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LETTERS       = 26;
    localparam int FALLBACK_MULT = 25;
    localparam int PRINT_CAP     = 40;

    typedef struct packed {
        t_letter first_out;
        t_letter second_out;
        logic    key_not_invertible;
    } t_cipher_beat;

    // shadow of the key registers, taken from apb writes
    t_letter key_tl;
    t_letter key_tr;
    t_letter key_bl;
    t_letter key_br;
    logic    decrypt_on;

    t_cipher_beat owed_beats[$];
    int           fail_count = 0;

    assign o_fail_count = fail_count;

    // one letter pair through the current key, encrypt or decrypt
    function automatic t_cipher_beat hill_transform(input t_letter p0_raw,
                                                    input t_letter p1_raw);
        int           p0, p1, a, b, c, d;
        int           det, inv, x;
        int           m00, m01, m10, m11;
        t_cipher_beat beat;
        p0 = int'(p0_raw) % LETTERS;
        p1 = int'(p1_raw) % LETTERS;
        a  = int'(key_tl) % LETTERS;
        b  = int'(key_tr) % LETTERS;
        c  = int'(key_bl) % LETTERS;
        d  = int'(key_br) % LETTERS;
        beat.key_not_invertible = 1'b0;
        if (decrypt_on) begin
            det = (a * d + LETTERS - (b * c) % LETTERS) % LETTERS;
            inv = 0;
            for (x = 1; x < LETTERS; x++) begin
                if (inv == 0 && (det * x) % LETTERS == 1) begin
                    inv = x;
                end
            end
            if (inv == 0) begin
                inv = FALLBACK_MULT;
                beat.key_not_invertible = 1'b1;
            end
            m00 = (d * inv) % LETTERS;
            m01 = (((LETTERS - b) % LETTERS) * inv) % LETTERS;
            m10 = (((LETTERS - c) % LETTERS) * inv) % LETTERS;
            m11 = (a * inv) % LETTERS;
        end else begin
            m00 = a;
            m01 = b;
            m10 = c;
            m11 = d;
        end
        beat.first_out  = t_letter'((m00 * p0 + m01 * p1) % LETTERS);
        beat.second_out = t_letter'((m10 * p0 + m11 * p1) % LETTERS);
        return beat;
    endfunction

    task automatic report_mismatch(input string what, input t_letter got,
                                   input t_letter want);
        fail_count++;
        if (fail_count <= PRINT_CAP) begin
            $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_cipher_beat want;
        if (!i_rst_n) begin
            key_tl     = '0;
            key_tr     = '0;
            key_bl     = '0;
            key_br     = '0;
            decrypt_on = 1'b0;
            owed_beats.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (t_reg_idx'(paddr[APB_AW-1:2]))
                    REG_KEY_TL: key_tl = pwdata[LETTER_W-1:0];
                    REG_KEY_TR: key_tr = pwdata[LETTER_W-1:0];
                    REG_KEY_BL: key_bl = pwdata[LETTER_W-1:0];
                    REG_KEY_BR: key_br = pwdata[LETTER_W-1:0];
                    REG_MODE:   decrypt_on = pwdata[0];
                    default: ;
                endcase
            end
            if (i_pair.valid === 1'b1 && i_pair.ready === 1'b1) begin
                owed_beats.push_back(hill_transform(i_pair.first_letter,
                                                    i_pair.second_letter));
            end
            if (i_result.valid === 1'b1 && i_result.ready === 1'b1) begin
                if (owed_beats.size() == 0) begin
                    report_mismatch("unexpected beat, first_out", i_result.first_out, '0);
                end else begin
                    want = owed_beats.pop_front();
                    if (i_result.first_out !== want.first_out) begin
                        report_mismatch("first_out", i_result.first_out, want.first_out);
                    end
                    if (i_result.second_out !== want.second_out) begin
                        report_mismatch("second_out", i_result.second_out,
                                        want.second_out);
                    end
                    if (i_result.key_not_invertible !== want.key_not_invertible) begin
                        report_mismatch("key_not_invertible",
                                        t_letter'(i_result.key_not_invertible),
                                        t_letter'(want.key_not_invertible));
                    end
                end
            end
        end
        o_results_owed <= owed_beats.size();
    end

endmodule

`default_nettype wire

FILE: bench/hill_cipher_2x2_top_tb.sv
`default_nettype none

module hill_cipher_2x2_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hc_pkg::*;

    // spare register slots, writes there must leave the key alone
    localparam t_reg_idx REG_SPARE_A = 3'd5;
    localparam t_reg_idx REG_SPARE_B = 3'd6;
    localparam t_reg_idx REG_SPARE_C = 3'd7;

    localparam int RESET_CYCLES     = 7;
    localparam int SETTLE_GAP       = 8;
    localparam int HOLD_OFF_CYCLES  = 200;
    localparam int RAND_PHASES      = 10;
    localparam int ITEMS_PER_PHASE  = 103;
    localparam int PRESSURE_PHASE   = 3;
    localparam int CYCLE_LIMIT      = 800000;

    logic clk = 1'b0;
    logic rst_n;

    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    wire  [APB_DW-1:0] prdata;
    wire               pready;

    int   fail_count;
    int   results_owed;

    // control between the stimulus and the result ready process
    logic steady_mode   = 1'b0;
    int   hold_off_reqs = 0;

    hc_in_if  pair_if ();
    hc_out_if result_if ();

    hill_cipher_2x2_top i_dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_pair   (pair_if),
        .o_result (result_if),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    hc_result_checker i_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_pair         (pair_if),
        .i_result       (result_if),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .o_fail_count   (fail_count),
        .o_results_owed (results_owed)
    );

    always #2ns clk = ~clk;

    // idle length: mostly short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return $urandom_range(1, 2);
        end else if (r < 95) begin
            return $urandom_range(3, 8);
        end
        return $urandom_range(20, 60);
    endfunction

    // sender gap before a beat, zero for about half of them
    function automatic int sender_gap();
        if ($urandom_range(0, 99) < 55) begin
            return 0;
        end
        return idle_len();
    endfunction

    // letter index, with the out-of-range codes 26..31 now and then
    function automatic t_letter rand_letter();
        if ($urandom_range(0, 9) == 0) begin
            return t_letter'($urandom_range(26, 31));
        end
        return t_letter'($urandom_range(0, 25));
    endfunction

    // key letter, with extremes and out-of-range codes mixed in
    function automatic t_letter rand_key_letter();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            return t_letter'($urandom_range(26, 31));
        end else if (r == 1) begin
            return ($urandom_range(0, 1) != 0) ? t_letter'(25) : t_letter'(0);
        end
        return t_letter'($urandom_range(0, 25));
    endfunction

    // apb write: setup, access, then idle
    task automatic reg_write(input t_reg_idx idx, input logic [APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // full key and mode load, junk in the bits above each register
    task automatic load_key(input t_letter tl, input t_letter tr, input t_letter bl,
                            input t_letter br, input logic decrypt);
        logic [APB_DW-1:0] junk;
        junk = $urandom;
        reg_write(REG_KEY_TL, {junk[APB_DW-1:LETTER_W], tl});
        junk = $urandom;
        reg_write(REG_KEY_TR, {junk[APB_DW-1:LETTER_W], tr});
        junk = $urandom;
        reg_write(REG_KEY_BL, {junk[APB_DW-1:LETTER_W], bl});
        junk = $urandom;
        reg_write(REG_KEY_BR, {junk[APB_DW-1:LETTER_W], br});
        junk = $urandom;
        reg_write(REG_MODE, {junk[APB_DW-1:1], decrypt});
    endtask

    // one input beat, held until the block takes it
    task automatic send_pair(input t_letter p0, input t_letter p1);
        int gap;
        gap = steady_mode ? 0 : sender_gap();
        if (gap > 0) begin
            pair_if.valid         <= 1'b0;
            pair_if.first_letter  <= t_letter'($urandom);
            pair_if.second_letter <= t_letter'($urandom);
            repeat (gap) @(posedge clk);
        end
        pair_if.valid         <= 1'b1;
        pair_if.first_letter  <= p0;
        pair_if.second_letter <= p1;
        @(posedge clk);
        while (pair_if.ready !== 1'b1) @(posedge clk);
    endtask

    // stop sending and wait until every owed result is back
    task automatic drain_all();
        pair_if.valid <= 1'b0;
        @(posedge clk);
        while (results_owed != 0) @(posedge clk);
        repeat (SETTLE_GAP) @(posedge clk);
    endtask

    // result side ready: random stalls, plus a long hold-off on request
    initial begin : result_ready_gen
        int served;
        served = 0;
        result_if.ready <= 1'b0;
        forever begin
            if (hold_off_reqs != served) begin
                // long hold-off so the queue fills and the input stalls
                served = hold_off_reqs;
                result_if.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end else if (steady_mode || $urandom_range(0, 3) != 0) begin
                result_if.ready <= 1'b1;
                @(posedge clk);
            end else begin
                result_if.ready <= 1'b0;
                repeat (idle_len()) @(posedge clk);
            end
        end
    end

    // run limit
    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("status: fail");
        $finish;
    end

    initial begin : stimulus
        int phase;
        int n;

        // known values on every input from time zero
        rst_n                 <= 1'b0;
        pair_if.valid         <= 1'b0;
        pair_if.first_letter  <= '0;
        pair_if.second_letter <= '0;
        psel                  <= 1'b0;
        penable               <= 1'b0;
        pwrite                <= 1'b0;
        paddr                 <= '0;
        pwdata                <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // ---- directed part ----

        // reset key: all zero, encrypt, so every pair maps to zero
        send_pair(5'd0, 5'd0);
        send_pair(5'd31, 5'd31);
        drain_all();

        // largest key letters, letters at and above the alphabet edge
        load_key(5'd25, 5'd25, 5'd25, 5'd25, 1'b0);
        send_pair(5'd25, 5'd25);
        send_pair(5'd26, 5'd0);
        send_pair(5'd0, 5'd27);
        send_pair(5'd31, 5'd30);
        send_pair(5'd1, 5'd0);
        send_pair(5'd0, 5'd1);
        drain_all();

        // invertible key, decrypt; spare register writes must be dropped
        load_key(5'd3, 5'd3, 5'd2, 5'd5, 1'b1);
        reg_write(REG_SPARE_A, 32'hFFFF_FFFF);
        reg_write(REG_SPARE_B, 32'h0000_0013);
        reg_write(REG_SPARE_C, 32'hA5A5_A5A5);
        send_pair(5'd7, 5'd8);
        send_pair(5'd0, 5'd25);
        send_pair(5'd25, 5'd0);
        send_pair(5'd28, 5'd29);
        drain_all();

        // key letters above 25 fold down, determinant zero
        load_key(5'd31, 5'd0, 5'd0, 5'd26, 1'b1);
        send_pair(5'd3, 5'd11);
        send_pair(5'd25, 5'd24);
        drain_all();

        // determinant 13, no inverse
        load_key(5'd1, 5'd0, 5'd0, 5'd13, 1'b1);
        send_pair(5'd4, 5'd9);
        send_pair(5'd17, 5'd2);
        drain_all();

        // even determinant, no inverse
        load_key(5'd2, 5'd0, 5'd0, 5'd1, 1'b1);
        send_pair(5'd12, 5'd6);
        send_pair(5'd25, 5'd25);
        drain_all();

        // encrypt with a singular key: flag stays low
        load_key(5'd2, 5'd4, 5'd6, 5'd8, 1'b0);
        send_pair(5'd10, 5'd20);
        send_pair(5'd31, 5'd1);
        drain_all();

        // determinant 25, its own inverse
        load_key(5'd0, 5'd1, 5'd1, 5'd0, 1'b1);
        send_pair(5'd5, 5'd19);
        send_pair(5'd0, 5'd29);
        drain_all();

        // ---- random part ----
        for (phase = 0; phase < RAND_PHASES; phase++) begin
            // first phase runs with no idling on either side
            steady_mode = (phase == 0);
            load_key(rand_key_letter(), rand_key_letter(), rand_key_letter(),
                     rand_key_letter(), phase[0]);
            if (phase == PRESSURE_PHASE) begin
                // sender keeps offering while the receiver holds off
                steady_mode = 1'b1;
                hold_off_reqs++;
            end
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                // now and then pause until all results are back
                if (!steady_mode && $urandom_range(0, 99) == 0) begin
                    drain_all();
                end
                send_pair(rand_letter(), rand_letter());
            end
            drain_all();
        end

        // verdict
        steady_mode = 1'b0;
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: hill_cipher_2x2_top.f
+incdir+rtl/core
rtl/core/hc_pkg.sv
rtl/core/hc_chan_if.sv
rtl/core/hc_key.sv
rtl/core/hc_front.sv
rtl/core/hc_fifo.sv
rtl/core/hc_back.sv
rtl/core/hill_cipher_2x2_top.sv
bench/hc_result_checker.sv
bench/hill_cipher_2x2_top_tb.sv
